[src/dec96r_pkg.sv]
// Package with the types, constants and helper functions of the decimal rounding block.
package dec96r_pkg;

	// Mantissa and arithmetic widths.
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned MANT_W       = 3 * WORD_W;
	localparam int unsigned SCALE_W      = 5;
	localparam int unsigned DIV_W        = 30;
	localparam int unsigned CHUNK_W      = 4;
	localparam int unsigned CNT_W        = $clog2(MANT_W);
	localparam int unsigned SCALE_LIMIT  = 28;
	localparam int unsigned CHUNK_DIGITS = 9;

	// One input transaction.
	typedef struct packed {
		logic [WORD_W-1:0]  mant_low;
		logic [WORD_W-1:0]  mant_middle;
		logic [WORD_W-1:0]  mant_high;
		logic               in_negative;
		logic [SCALE_W-1:0] in_scale;
		logic [SCALE_W-1:0] target_decimals;
	} dec_in_t;

	// One result transaction.
	typedef struct packed {
		logic [WORD_W-1:0]  res_low;
		logic [WORD_W-1:0]  res_middle;
		logic [WORD_W-1:0]  res_high;
		logic               res_negative;
		logic [SCALE_W-1:0] res_scale;
	} dec_out_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV   = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_HOLD  = 4'b1000
	} dec_state_t;

	// Number of digits taken off in the next chunk: at most nine.
	function automatic logic [CHUNK_W-1:0] chunk_of(input logic [SCALE_W-1:0] diff);
		logic [CHUNK_W-1:0] chunk;
		if (diff > SCALE_W'(CHUNK_DIGITS)) begin
			chunk = CHUNK_W'(CHUNK_DIGITS);
		end else begin
			chunk = diff[CHUNK_W-1:0];
		end
		return chunk;
	endfunction

	// Powers of ten from one to ten to the ninth.
	function automatic logic [DIV_W-1:0] pow_ten(input logic [CHUNK_W-1:0] digits);
		logic [DIV_W-1:0] value;
		case (digits)
			4'd0:    value = DIV_W'(1);
			4'd1:    value = DIV_W'(10);
			4'd2:    value = DIV_W'(100);
			4'd3:    value = DIV_W'(1000);
			4'd4:    value = DIV_W'(10000);
			4'd5:    value = DIV_W'(100000);
			4'd6:    value = DIV_W'(1000000);
			4'd7:    value = DIV_W'(10000000);
			4'd8:    value = DIV_W'(100000000);
			default: value = DIV_W'(1000000000);
		endcase
		return value;
	endfunction

endpackage

[src/dec96r_in_if.sv]
// Input channel interface of the decimal rounding block.
interface dec96r_in_if;
	import dec96r_pkg::*;

	logic    valid;
	logic    ready;
	dec_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/dec96r_out_if.sv]
// Result channel interface of the decimal rounding block.
interface dec96r_out_if;
	import dec96r_pkg::*;

	logic     valid;
	logic     ready;
	dec_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/decimal96_round_half_away.sv]
// Top level of the decimal rounding block, midpoints rounded away from zero.
//
// The block takes one decimal value per transaction on the req channel: a 96-bit
// mantissa in three words, a sign, a scale and a target count of decimals. It
// returns one transaction on the rsp channel with the rounded mantissa, the sign
// and the new scale. Both channels use a valid/ready handshake.
// When the scale exceeds the (clamped) target, the mantissa is divided by ten to
// the difference in chunks of up to nine digits, one quotient bit per cycle in a
// restoring divider with a 30-bit remainder. Each chunk is a pass over all 96
// mantissa bits; a rounding step follows the last chunk. An item that passes
// unchanged goes straight to the hold state for the result register.
// One item is in the divider at a time; req.ready is high only while it is free,
// so a new item is accepted no sooner than the cycle after the result is loaded.
// The result sits in an output register, so a new item may be accepted and
// worked on while the previous result waits for rsp.ready. If that result is
// still not taken when the next one is done, the divider holds until it is.
// Reset clears the sequencer and the output valid flag; no clearing pass is
// needed and the block accepts an item in the first cycle after reset.
module decimal96_round_half_away (
	input logic                clk,
	input logic                arst_n,
	dec96r_in_if.sink          req,
	dec96r_out_if.source       rsp
);
	import dec96r_pkg::*;

	dec_state_t          state_q;
	logic [MANT_W-1:0]   mant_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    div_q;
	logic [SCALE_W-1:0]  diff_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                round_q;
	logic                neg_q;
	logic [SCALE_W-1:0]  scale_q;
	logic                out_valid_q;
	dec_out_t            out_data_q;

	logic                accept;
	logic                out_free;
	logic [SCALE_W-1:0]  target;
	logic [SCALE_W-1:0]  in_diff;
	logic [DIV_W:0]      trial;
	logic                quot_bit;
	logic [DIV_W-1:0]    rem_next;
	logic [SCALE_W-1:0]  diff_next;
	logic [CHUNK_W-1:0]  chunk;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	// Clamp the target and find how many digits must be removed.
	always_comb begin
		if (req.data.target_decimals > SCALE_W'(SCALE_LIMIT)) begin
			target = SCALE_W'(SCALE_LIMIT);
		end else begin
			target = req.data.target_decimals;
		end
		in_diff = req.data.in_scale - target;
	end

	// One restoring division step: bring down the next mantissa bit.
	always_comb begin
		trial     = {rem_q, mant_q[MANT_W-1]};
		quot_bit  = (trial >= {1'b0, div_q});
		rem_next  = quot_bit ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
		chunk     = chunk_of(diff_q);
		diff_next = diff_q - SCALE_W'(chunk);
	end

	// Sequencer control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (req.data.in_scale > target) begin
							state_q <= ST_DIV;
						end else begin
							state_q <= ST_HOLD;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(MANT_W - 1)) begin
						cnt_q <= '0;
						if (diff_next == '0) begin
							state_q <= ST_ROUND;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_ROUND: begin
					state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: mantissa shift register, remainder and chunk bookkeeping.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mant_q  <= {req.data.mant_high, req.data.mant_middle, req.data.mant_low};
					neg_q   <= req.data.in_negative;
					rem_q   <= '0;
					round_q <= 1'b0;
					diff_q  <= in_diff;
					div_q   <= pow_ten(chunk_of(in_diff));
					if (req.data.in_scale > target) begin
						scale_q <= target;
					end else begin
						scale_q <= req.data.in_scale;
					end
				end
			end
			ST_DIV: begin
				mant_q <= {mant_q[MANT_W-2:0], quot_bit};
				if (cnt_q == CNT_W'(MANT_W - 1)) begin
					// End of a chunk: note the rounding decision and start the next one.
					round_q <= (rem_next >= (div_q >> 1));
					diff_q  <= diff_next;
					div_q   <= pow_ten(chunk_of(diff_next));
					rem_q   <= '0;
				end else begin
					rem_q <= rem_next;
				end
			end
			ST_ROUND: begin
				if (round_q) begin
					mant_q <= mant_q + MANT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded when the result is ready and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_HOLD) && out_free) begin
			out_data_q.res_low      <= mant_q[WORD_W-1:0];
			out_data_q.res_middle   <= mant_q[2*WORD_W-1:WORD_W];
			out_data_q.res_high     <= mant_q[MANT_W-1:2*WORD_W];
			out_data_q.res_negative <= neg_q;
			out_data_q.res_scale    <= scale_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

endmodule

[tb/tb.sv]
// Testbench for the decimal rounding block: predicted results checked against every result transaction.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dec96r_pkg::*;

	localparam int unsigned CYCLE_LIMIT      = 1_000_000;
	localparam int unsigned LONG_HOLD        = 800;
	localparam int unsigned DRAIN_CYCLES     = 400;
	localparam int unsigned RANDOM_PER_PHASE = 120;
	localparam int unsigned PRESSURE_ITEMS   = 16;
	localparam int unsigned MAX_REPORTS      = 10;

	// Traffic phases of the run.
	typedef enum logic [2:0] {
		PH_STEADY,
		PH_BACKPRESSURE,
		PH_SENDER_GAPS,
		PH_RECEIVER_STALLS,
		PH_BOTH_IDLE
	} traffic_phase_t;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           drv_valid = 1'b0;
	dec_in_t        drv_data = '0;
	logic           recv_ready = 1'b0;
	logic           item_taken = 1'b0;
	traffic_phase_t phase = PH_STEADY;
	int unsigned    hold_count = 0;
	int unsigned    queued_total = 0;
	int unsigned    sent_total = 0;
	int unsigned    failure_count = 0;
	int unsigned    cycle_count = 0;

	dec_in_t  pending_items[$];
	dec_out_t expected_results[$];

	dec96r_in_if  req_ch ();
	dec96r_out_if rsp_ch ();

	assign req_ch.valid = drv_valid;
	assign req_ch.data  = drv_data;
	assign rsp_ch.ready = recv_ready;

	decimal96_round_half_away DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Ten to the given power, for chunks of up to nine digits.
	function automatic logic [31:0] ten_to(input int unsigned digits);
		logic [31:0] p;
		p = 32'd1;
		repeat (digits) p = p * 32'd10;
		return p;
	endfunction

	// Rounds the mantissa down to the target scale, midpoints away from zero.
	function automatic dec_out_t round_half_away(input dec_in_t d);
		dec_out_t    r;
		logic [95:0] m;
		logic [31:0] dv;
		logic [31:0] rem;
		logic [4:0]  tgt;
		int unsigned left;
		int unsigned chunk;
		m   = {d.mant_high, d.mant_middle, d.mant_low};
		tgt = (d.target_decimals > SCALE_LIMIT) ? 5'(SCALE_LIMIT) : d.target_decimals;
		r.res_scale    = d.in_scale;
		r.res_negative = d.in_negative;
		dv  = 32'd1;
		rem = 32'd0;
		if (d.in_scale > tgt) begin
			left = d.in_scale - tgt;
			// Only the remainder of the last chunk decides the rounding.
			while (left > 0) begin
				chunk = (left > CHUNK_DIGITS) ? CHUNK_DIGITS : left;
				dv    = ten_to(chunk);
				rem   = 32'(m % 96'(dv));
				m     = m / 96'(dv);
				left  = left - chunk;
			end
			if (rem >= (dv >> 1)) begin
				m = m + 96'd1;
			end
			r.res_scale = tgt;
		end
		r.res_low    = m[31:0];
		r.res_middle = m[63:32];
		r.res_high   = m[95:64];
		return r;
	endfunction

	function automatic dec_in_t make_item(input logic [95:0] mant, input logic neg,
			input int unsigned scale, input int unsigned tgt);
		dec_in_t d;
		d.mant_low        = mant[31:0];
		d.mant_middle     = mant[63:32];
		d.mant_high       = mant[95:64];
		d.in_negative     = neg;
		d.in_scale        = 5'(scale);
		d.target_decimals = 5'(tgt);
		return d;
	endfunction

	// Random decimal value: plain random words, small values, boundary words,
	// or a value placed at or next to a rounding midpoint.
	function automatic dec_in_t random_item();
		dec_in_t     d;
		logic [95:0] m;
		logic [31:0] p;
		int unsigned digits;
		int unsigned scale;
		int unsigned tgt;
		scale = ($urandom_range(99, 0) < 88) ? $urandom_range(28, 0) : $urandom_range(31, 29);
		tgt   = ($urandom_range(99, 0) < 85) ? $urandom_range(28, 0) : $urandom_range(31, 29);
		case ($urandom_range(7, 0))
			0, 1, 2: begin
				m = {$urandom, $urandom, $urandom};
			end
			3: begin
				m = {64'd0, $urandom} >> $urandom_range(31, 0);
			end
			4: begin
				for (int k = 0; k < 3; k++) begin
					case ($urandom_range(3, 0))
						0:       m[k*32 +: 32] = 32'd0;
						1:       m[k*32 +: 32] = 32'hFFFF_FFFF;
						2:       m[k*32 +: 32] = 32'h8000_0000 ^ 32'($urandom_range(1, 0));
						default: m[k*32 +: 32] = $urandom;
					endcase
				end
			end
			default: begin
				digits = $urandom_range(9, 1);
				scale  = $urandom_range(28, digits);
				tgt    = scale - digits;
				p      = ten_to(digits);
				m      = 96'({$urandom, $urandom}) * 96'(p) + 96'(p >> 1)
					+ 96'($urandom_range(2, 0)) - 96'd1;
			end
		endcase
		d = make_item(m, 1'($urandom_range(1, 0)), scale, tgt);
		return d;
	endfunction

	function automatic bit idle_roll(input int unsigned pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	task automatic queue_item(input dec_in_t d);
		pending_items.push_back(d);
		queued_total++;
	endtask

	task automatic wait_all_taken();
		while (sent_total != queued_total) @(posedge clk);
	endtask

	task automatic note_failure(input string what, input dec_out_t want, input dec_out_t got);
		if (failure_count < MAX_REPORTS) begin
			$display("%s: expected %h_%h_%h neg=%0b scale=%0d, got %h_%h_%h neg=%0b scale=%0d",
				what, want.res_high, want.res_middle, want.res_low, want.res_negative,
				want.res_scale, got.res_high, got.res_middle, got.res_low, got.res_negative,
				got.res_scale);
		end
		failure_count++;
	endtask

	// Clock.
	initial begin
		forever #1 clk = ~clk;
	end

	// Cycle counter that ends a hung run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Driver: presents the next pending transaction, with random gaps in some phases.
	always @(negedge clk) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else if (!drv_valid || item_taken) begin
			if (pending_items.size() != 0 && !idle_roll(phase == PH_SENDER_GAPS ? 56 :
					phase == PH_BOTH_IDLE ? 34 : 0)) begin
				drv_data  <= pending_items.pop_front();
				drv_valid <= 1'b1;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, and one long hold-off that fills the block up.
	always @(negedge clk) begin
		if (!arst_n) begin
			recv_ready <= 1'b0;
		end else if (phase == PH_BACKPRESSURE && hold_count < LONG_HOLD) begin
			recv_ready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			recv_ready <= !idle_roll(phase == PH_RECEIVER_STALLS ? 56 :
				phase == PH_BOTH_IDLE ? 34 : 0);
		end
	end

	// Monitor: checks each result, then records the prediction for each accepted input.
	always @(posedge clk) begin
		dec_out_t want;
		dec_out_t got;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (expected_results.size() == 0) begin
					note_failure("unexpected result", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got.res_low !== want.res_low || got.res_middle !== want.res_middle ||
							got.res_high !== want.res_high ||
							got.res_negative !== want.res_negative ||
							got.res_scale !== want.res_scale) begin
						note_failure("mismatch", want, got);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(round_half_away(req_ch.data));
				sent_total <= sent_total + 1;
			end
			item_taken <= req_ch.valid && req_ch.ready;
		end
	end

	// Stimulus and end of run.
	initial begin
		// Directed cases: extremes, midpoints, carries, clamping and pass-through.
		queue_item(make_item(96'd0, 1'b0, 0, 0));
		queue_item(make_item('1, 1'b1, 0, 0));
		queue_item(make_item('1, 1'b0, 1, 0));
		queue_item(make_item('1, 1'b1, 28, 0));
		queue_item(make_item('1, 1'b0, 31, 0));
		queue_item(make_item('1, 1'b0, 28, 28));
		queue_item(make_item('1, 1'b1, 31, 31));
		queue_item(make_item(96'd123456789, 1'b0, 30, 31));
		queue_item(make_item(96'd987654321, 1'b1, 29, 29));
		queue_item(make_item(96'd77, 1'b0, 5, 20));
		queue_item(make_item(96'd5, 1'b0, 1, 0));
		queue_item(make_item(96'd5, 1'b1, 1, 0));
		queue_item(make_item(96'd4, 1'b1, 1, 0));
		queue_item(make_item(96'd25, 1'b0, 1, 0));
		queue_item(make_item(96'd500000000, 1'b0, 9, 0));
		queue_item(make_item(96'd499999999, 1'b1, 9, 0));
		queue_item(make_item(96'd5000000000, 1'b0, 10, 0));
		queue_item(make_item(96'd4999999999, 1'b0, 10, 0));
		queue_item(make_item(96'd45000000000, 1'b1, 11, 0));
		queue_item(make_item(96'hFFFF_FFFF * 10 + 9, 1'b0, 1, 0));
		queue_item(make_item(96'hFFFF_FFFF_FFFF_FFFF * 10 + 5, 1'b1, 1, 0));
		queue_item(make_item({32'h8000_0000, 32'h00FF_0000, 32'h8000_0000}, 1'b0, 27, 0));
		queue_item(make_item({32'h00FF_0000, 32'hFFFF_FFFF, 32'h0000_0001}, 1'b1, 18, 0));
		queue_item(make_item('1, 1'b0, 19, 1));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Random traffic, one batch per phase.
		for (int ph = PH_STEADY; ph <= PH_BOTH_IDLE; ph++) begin
			phase = traffic_phase_t'(ph);
			repeat (phase == PH_BACKPRESSURE ? PRESSURE_ITEMS : RANDOM_PER_PHASE) begin
				queue_item(random_item());
			end
			wait_all_taken();
		end

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failure_count == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[filelist.f]
src/dec96r_pkg.sv
src/dec96r_in_if.sv
src/dec96r_out_if.sv
src/decimal96_round_half_away.sv
tb/tb.sv
